// ===== src/bile_pkg.sv =====
// bile_pkg: shared types and constants for the bounded integer list engine
// holds operation and status codes, word widths and the default list depth
// no dependencies
package bile_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 4;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_APPEND    = 3'd1,
        OP_REM_FIRST = 3'd2,
        OP_REM_LAST  = 3'd3,
        OP_CONTAINS  = 3'd4,
        OP_COUNT     = 3'd5,
        OP_INDEX     = 3'd6,
        OP_FETCH     = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

// ===== src/bounded_integer_list_engine_top.sv =====
// bounded_integer_list_engine_top: ordered list of signed words in a ring store
// insert and remove finish in the execute step; fetch reads the store in the execute step
// and answers from the fetch step; contains, count and index of walk the list in the scan step;
// one word in flight at a time, the scan reads one stored entry per cycle through
// the single read port of the entry store and one shared equality compare
// reset (rst_n, async, active low) empties the list; store contents stay undefined
// the result strobe lasts one cycle and the receiver cannot stall it
// depends on bile_pkg
module bounded_integer_list_engine_top #(
    parameter int DEPTH = bile_pkg::DEPTH_DEFAULT,
    localparam int LEN_W = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          start,
    output logic                          busy,
    input  logic [bile_pkg::OP_W-1:0]     operation,
    input  logic signed [bile_pkg::DATA_W-1:0] value,
    input  logic [bile_pkg::POS_W-1:0]    position,
    // result side
    output logic                          done,
    output logic [bile_pkg::STATUS_W-1:0] status,
    output logic                          found,
    output logic signed [bile_pkg::DATA_W-1:0] result_value,
    output logic [LEN_W-1:0]              list_length
);

    localparam int DATA_W = bile_pkg::DATA_W;
    localparam int POS_W  = bile_pkg::POS_W;
    localparam int PTR_W  = $clog2(DEPTH);
    // wide enough for a ring pointer plus a length or a position
    localparam int SUM_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [LEN_W-1:0] FULL_LEN  = LEN_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    // sequencer: latch the word, do the single-step work, read the store for a fetch, or walk the list
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FETCH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    bile_pkg::op_t         op_reg, op_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    // list bookkeeping
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [LEN_W-1:0]      count_reg, count_next;

    // scan bookkeeping: issue side and compare side of the read pipeline
    logic [LEN_W-1:0]      issue_idx_reg, issue_idx_next;
    logic [PTR_W-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [PTR_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [LEN_W-1:0]      match_cnt_reg, match_cnt_next;

    // result word
    logic                  done_reg, done_next;
    bile_pkg::status_t     status_reg, status_next;
    logic                  found_reg, found_next;
    logic [DATA_W-1:0]     result_reg, result_next;
    logic [LEN_W-1:0]      length_reg, length_next;

    // entry store port
    logic [DATA_W-1:0]     mem [DEPTH];
    logic [DATA_W-1:0]     rd_data_reg;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;

    // helpers
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      front_inc;
    logic [PTR_W-1:0]      scan_ptr_inc;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      tail_slot;
    logic [SUM_W-1:0]      fetch_sum;
    logic [PTR_W-1:0]      fetch_slot;
    logic                  pos_out_of_range;
    logic                  issue_done;
    logic                  match;
    logic [LEN_W-1:0]      match_total;
    logic                  early_stop_op;

    // ring pointer arithmetic, each one compare and one add or subtract
    assign front_dec    = (front_reg == '0) ? LAST_PTR : front_reg - PTR_W'(1);
    assign front_inc    = (front_reg == LAST_PTR) ? '0 : front_reg + PTR_W'(1);
    assign scan_ptr_inc = (scan_ptr_reg == LAST_PTR) ? '0 : scan_ptr_reg + PTR_W'(1);

    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign tail_slot = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                               : PTR_W'(tail_sum);
    assign fetch_sum  = SUM_W'(front_reg) + SUM_W'(pos_reg);
    assign fetch_slot = (fetch_sum >= DEPTH_SUM) ? PTR_W'(fetch_sum - DEPTH_SUM)
                                                 : PTR_W'(fetch_sum);
    assign pos_out_of_range = SUM_W'(pos_reg) >= SUM_W'(count_reg);

    // shared compare on the word read in the previous cycle
    assign issue_done    = issue_idx_reg >= count_reg;
    assign match         = rd_valid_reg && (rd_data_reg == value_reg);
    assign match_total   = match_cnt_reg + LEN_W'(match);
    assign early_stop_op = (op_reg == bile_pkg::OP_CONTAINS) ||
                           (op_reg == bile_pkg::OP_INDEX);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_valid_next  = 1'b0;
        match_cnt_next = match_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        result_next    = result_reg;
        length_next    = length_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = front_dec;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = bile_pkg::op_t'(operation);
                    value_next     = value;
                    pos_next       = position;
                    issue_idx_next = '0;
                    scan_ptr_next  = front_reg;
                    match_cnt_next = '0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // default word for the operations decided in the execute step
                status_next = bile_pkg::ST_OK;
                found_next  = 1'b0;
                result_next = '0;
                case (op_reg)
                    bile_pkg::OP_INS_FRONT:
                    begin
                        if (count_reg == FULL_LEN)
                        begin
                            status_next = bile_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = front_dec;
                            front_next = front_dec;
                            count_next = count_reg + LEN_W'(1);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bile_pkg::OP_APPEND:
                    begin
                        if (count_reg == FULL_LEN)
                        begin
                            status_next = bile_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = tail_slot;
                            count_next = count_reg + LEN_W'(1);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bile_pkg::OP_REM_FIRST:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bile_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            front_next = front_inc;
                            count_next = count_reg - LEN_W'(1);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bile_pkg::OP_REM_LAST:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bile_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - LEN_W'(1);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bile_pkg::OP_FETCH:
                    begin
                        if (pos_out_of_range)
                        begin
                            status_next = bile_pkg::ST_RANGE;
                            result_next = '1;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = fetch_slot;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        // contains, count, index of
                        state_next = S_SCAN;
                    end
                endcase
                length_next = count_next;
            end

            S_FETCH:
            begin
                status_next = bile_pkg::ST_OK;
                found_next  = 1'b1;
                result_next = rd_data_reg;
                length_next = count_reg;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_SCAN:
            begin
                // issue the next read while the previous word is compared
                if (!issue_done)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_ptr_reg;
                    rd_valid_next  = 1'b1;
                    cmp_idx_next   = PTR_W'(issue_idx_reg);
                    issue_idx_next = issue_idx_reg + LEN_W'(1);
                    scan_ptr_next  = scan_ptr_inc;
                end
                match_cnt_next = match_total;

                status_next = bile_pkg::ST_OK;
                length_next = count_reg;
                if (early_stop_op && match)
                begin
                    // first match ends contains and index of
                    found_next  = 1'b1;
                    result_next = (op_reg == bile_pkg::OP_INDEX) ? DATA_W'(cmp_idx_reg)
                                                                 : DATA_W'(1);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (issue_done)
                begin
                    // last stored word compared this cycle (or the list is empty)
                    if (op_reg == bile_pkg::OP_COUNT)
                    begin
                        found_next  = (match_total != '0);
                        result_next = DATA_W'(match_total);
                    end
                    else
                    begin
                        found_next  = 1'b0;
                        result_next = (op_reg == bile_pkg::OP_INDEX) ? '1 : '0;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        value_reg     <= value_next;
        pos_reg       <= pos_next;
        issue_idx_reg <= issue_idx_next;
        scan_ptr_reg  <= scan_ptr_next;
        cmp_idx_reg   <= cmp_idx_next;
        match_cnt_reg <= match_cnt_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        result_reg    <= result_next;
        length_reg    <= length_next;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign result_value = result_reg;
    assign list_length  = length_reg;

    // the strobe always comes as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    // an accepted word always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // scan never runs past the list length
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_idx_reg <= count_reg))
        else $error("scan index beyond list length");

    // a refused insert reports a full list
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == bile_pkg::ST_FULL)) |-> (length_reg == FULL_LEN))
        else $error("full status with list not full");

    // the length changes only at the end of an insert or removal
    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("list length changed outside execute step");

endmodule
